/* hw/rtl/drt_pkg.sv */
// drt_pkg: shared types, codes and defaults for the dirty rectangle tracker.
// Used by drt_ctrl, drt_datapath and dirty_rect_tracker; depends on nothing.
package drt_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int COORD_DEFAULT = 13;
  localparam int PORT_COORD_W  = 13;
  localparam int COUNT_W       = 5;
  localparam int MERGE_MIN     = 4;

  // request codes; the fourth code is unused and answers like a dropped mark
  localparam logic [1:0] REQ_MARK  = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_MAX    = 2'd3;

  localparam logic [12:0] WIDTH_RESET  = 13'd1920;
  localparam logic [12:0] HEIGHT_RESET = 13'd1080;
  localparam logic [4:0]  MAX_RESET    = 5'd16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_APPEND_CHK,
    S_I_CHECK,
    S_A_WAIT,
    S_J_CHECK,
    S_B_WAIT,
    S_MOVE,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_I,
    RD_J,
    RD_LAST
  } rsel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_APPEND,
    WR_COLLAPSE,
    WR_A,
    WR_MOVE
  } wsel_t;

  typedef struct packed {
    logic  latch;
    logic  rd_en;
    rsel_t rsel;
    wsel_t wsel;
    logic  clear;
    logic  dec_held;
    logic  clr_i;
    logic  inc_i;
    logic  set_j;
    logic  inc_j;
    logic  load_a;
    logic  merge_a;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic is_mark;
    logic is_clear;
    logic is_read;
    logic mark_ok;
    logic full;
    logic ge4;
    logic i_lt;
    logic j_lt;
    logic j_not_last;
    logic overlap;
  } stat_t;

endpackage

/* hw/rtl/drt_ctrl.sv */
// drt_ctrl: sequencer for requests and the forward merge pass.
// Depends on drt_pkg; drives drt_datapath through cmd_t, watches stat_t.
module drt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  drt_pkg::stat_t stat,
  output drt_pkg::cmd_t  cmd
);

  drt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      drt_pkg::S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = drt_pkg::S_DECODE;
        end
      end
      drt_pkg::S_DECODE: begin
        state_next = drt_pkg::S_DONE;
        if (stat.is_mark) begin
          if (stat.mark_ok) begin
            if (stat.full) begin
              cmd.wsel = drt_pkg::WR_COLLAPSE;
            end else begin
              cmd.wsel   = drt_pkg::WR_APPEND;
              state_next = drt_pkg::S_APPEND_CHK;
            end
          end
        end else if (stat.is_clear) begin
          cmd.clear = 1'b1;
        end else if (stat.is_read) begin
          cmd.rd_en = 1'b1;
          cmd.rsel  = drt_pkg::RD_IDX;
        end
      end
      drt_pkg::S_APPEND_CHK: begin
        if (stat.ge4) begin
          cmd.clr_i  = 1'b1;
          state_next = drt_pkg::S_I_CHECK;
        end else begin
          state_next = drt_pkg::S_DONE;
        end
      end
      drt_pkg::S_I_CHECK: begin
        if (stat.i_lt) begin
          cmd.rd_en  = 1'b1;
          cmd.rsel   = drt_pkg::RD_I;
          cmd.set_j  = 1'b1;
          state_next = drt_pkg::S_A_WAIT;
        end else begin
          state_next = drt_pkg::S_DONE;
        end
      end
      drt_pkg::S_A_WAIT: begin
        cmd.load_a = 1'b1;
        state_next = drt_pkg::S_J_CHECK;
      end
      drt_pkg::S_J_CHECK: begin
        if (stat.j_lt) begin
          cmd.rd_en  = 1'b1;
          cmd.rsel   = drt_pkg::RD_J;
          state_next = drt_pkg::S_B_WAIT;
        end else begin
          // write back the grown entry i and advance
          cmd.wsel   = drt_pkg::WR_A;
          cmd.inc_i  = 1'b1;
          state_next = drt_pkg::S_I_CHECK;
        end
      end
      drt_pkg::S_B_WAIT: begin
        if (stat.overlap) begin
          cmd.merge_a  = 1'b1;
          cmd.dec_held = 1'b1;
          if (stat.j_not_last) begin
            cmd.rd_en  = 1'b1;
            cmd.rsel   = drt_pkg::RD_LAST;
            state_next = drt_pkg::S_MOVE;
          end else begin
            state_next = drt_pkg::S_J_CHECK;
          end
        end else begin
          cmd.inc_j  = 1'b1;
          state_next = drt_pkg::S_J_CHECK;
        end
      end
      drt_pkg::S_MOVE: begin
        // last entry fills slot j and is checked again from the read register
        cmd.wsel   = drt_pkg::WR_MOVE;
        state_next = drt_pkg::S_B_WAIT;
      end
      drt_pkg::S_DONE: begin
        cmd.emit   = 1'b1;
        state_next = drt_pkg::S_IDLE;
      end
      default: begin
        state_next = drt_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != drt_pkg::S_IDLE);

endmodule

/* hw/rtl/drt_datapath.sv */
// drt_datapath: configuration registers, rectangle table, clipping and merge math.
// Depends on drt_pkg; commanded by drt_ctrl.
module drt_datapath #(
  parameter int TABLE_DEPTH = drt_pkg::DEPTH_DEFAULT,
  parameter int COORD_BITS  = drt_pkg::COORD_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_addr,
  input  logic [12:0]                 cfg_data,
  input  logic [1:0]                  req_type,
  input  logic signed [15:0]          rect_x,
  input  logic signed [15:0]          rect_y,
  input  logic [15:0]                 rect_width,
  input  logic [15:0]                 rect_height,
  input  logic [3:0]                  read_index,
  input  drt_pkg::cmd_t               cmd,
  output drt_pkg::stat_t              stat,
  output logic                        done,
  output logic [drt_pkg::COUNT_W-1:0] entry_count,
  output logic                        entry_valid,
  output logic [12:0]                 entry_x,
  output logic [12:0]                 entry_y,
  output logic [12:0]                 entry_width,
  output logic [12:0]                 entry_height
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int C  = COORD_BITS;

  // configuration
  logic        tracking_enable;
  logic [12:0] screen_width;
  logic [12:0] screen_height;
  logic [4:0]  max_entries;

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_enable <= 1'b1;
      screen_width    <= drt_pkg::WIDTH_RESET;
      screen_height   <= drt_pkg::HEIGHT_RESET;
      max_entries     <= drt_pkg::MAX_RESET;
    end else if (cfg_write) begin
      case (cfg_addr)
        drt_pkg::CFG_ENABLE: tracking_enable <= cfg_data[0];
        drt_pkg::CFG_WIDTH:  screen_width    <= cfg_data;
        drt_pkg::CFG_HEIGHT: screen_height   <= cfg_data;
        drt_pkg::CFG_MAX:    max_entries     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // latched request
  logic [1:0]         req_q;
  logic signed [15:0] x_q, y_q;
  logic [15:0]        w_q, h_q;
  logic [3:0]         idx_q;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q <= req_type;
      x_q   <= rect_x;
      y_q   <= rect_y;
      w_q   <= rect_width;
      h_q   <= rect_height;
      idx_q <= read_index;
    end
  end

  // clip to the screen by cutting
  logic signed [17:0] xs, ys, rs, bs, ls, ts, sws, shs, rc, bc, spx, spy;
  logic               clip_ok;
  logic [15:0]        ls16, ts16, spx16, spy16, sw16, sh16;

  always_comb begin
    xs      = {{2{x_q[15]}}, x_q};
    ys      = {{2{y_q[15]}}, y_q};
    rs      = xs + $signed({2'b00, w_q});
    bs      = ys + $signed({2'b00, h_q});
    ls      = x_q[15] ? 18'sd0 : xs;
    ts      = y_q[15] ? 18'sd0 : ys;
    sws     = $signed({5'b0, screen_width});
    shs     = $signed({5'b0, screen_height});
    rc      = (rs > sws) ? sws : rs;
    bc      = (bs > shs) ? shs : bs;
    clip_ok = (rc > ls) && (bc > ts);
    spx     = rc - ls;
    spy     = bc - ts;
    ls16    = ls[15:0];
    ts16    = ts[15:0];
    spx16   = spx[15:0];
    spy16   = spy[15:0];
    sw16    = 16'(screen_width);
    sh16    = 16'(screen_height);
  end

  // table
  logic [C-1:0] mem_l [TABLE_DEPTH];
  logic [C-1:0] mem_t [TABLE_DEPTH];
  logic [C-1:0] mem_w [TABLE_DEPTH];
  logic [C-1:0] mem_h [TABLE_DEPTH];
  logic [C-1:0] rd_l, rd_t, rd_w, rd_h;
  logic [C-1:0] a_l, a_t, a_w, a_h;
  logic [C-1:0] wd_l, wd_t, wd_w, wd_h;
  logic [IW-1:0] ra, wa;
  logic          we;

  logic [CW-1:0] held, i, j, held_m1;
  logic [7:0]    held8, idx8, j8, i8;

  assign held_m1 = held - 1'b1;
  assign held8   = 8'(held);
  assign idx8    = 8'(idx_q);
  assign j8      = 8'(j);
  assign i8      = 8'(i);

  always_comb begin
    case (cmd.rsel)
      drt_pkg::RD_IDX:  ra = idx8[IW-1:0];
      drt_pkg::RD_I:    ra = i[IW-1:0];
      drt_pkg::RD_J:    ra = j[IW-1:0];
      drt_pkg::RD_LAST: ra = held_m1[IW-1:0];
      default:          ra = '0;
    endcase
  end

  always_comb begin
    we   = 1'b1;
    wa   = '0;
    wd_l = a_l;
    wd_t = a_t;
    wd_w = a_w;
    wd_h = a_h;
    case (cmd.wsel)
      drt_pkg::WR_APPEND: begin
        wa   = held[IW-1:0];
        wd_l = ls16[C-1:0];
        wd_t = ts16[C-1:0];
        wd_w = spx16[C-1:0];
        wd_h = spy16[C-1:0];
      end
      drt_pkg::WR_COLLAPSE: begin
        wd_l = '0;
        wd_t = '0;
        wd_w = sw16[C-1:0];
        wd_h = sh16[C-1:0];
      end
      drt_pkg::WR_A: begin
        wa = i[IW-1:0];
      end
      drt_pkg::WR_MOVE: begin
        wa   = j[IW-1:0];
        wd_l = rd_l;
        wd_t = rd_t;
        wd_w = rd_w;
        wd_h = rd_h;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_l[wa] <= wd_l;
      mem_t[wa] <= wd_t;
      mem_w[wa] <= wd_w;
      mem_h[wa] <= wd_h;
    end
    if (cmd.rd_en) begin
      rd_l <= mem_l[ra];
      rd_t <= mem_t[ra];
      rd_w <= mem_w[ra];
      rd_h <= mem_h[ra];
    end
  end

  // overlap test and bounding box of entry i (held in a_*) and the read entry
  logic [C:0]   ar, ab, br, bb, mr, mb, mw, mh;
  logic [C-1:0] ml, mt;
  logic         overlap;

  always_comb begin
    ar      = {1'b0, a_l} + {1'b0, a_w};
    ab      = {1'b0, a_t} + {1'b0, a_h};
    br      = {1'b0, rd_l} + {1'b0, rd_w};
    bb      = {1'b0, rd_t} + {1'b0, rd_h};
    overlap = ({1'b0, a_l} < br) && (ar > {1'b0, rd_l}) &&
              ({1'b0, a_t} < bb) && (ab > {1'b0, rd_t});
    ml      = (a_l < rd_l) ? a_l : rd_l;
    mt      = (a_t < rd_t) ? a_t : rd_t;
    mr      = (ar > br) ? ar : br;
    mb      = (ab > bb) ? ab : bb;
    mw      = mr - {1'b0, ml};
    mh      = mb - {1'b0, mt};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      a_l <= rd_l;
      a_t <= rd_t;
      a_w <= rd_w;
      a_h <= rd_h;
    end else if (cmd.merge_a) begin
      a_l <= ml;
      a_t <= mt;
      a_w <= mw[C-1:0];
      a_h <= mh[C-1:0];
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (cmd.clear) begin
      held <= '0;
    end else if (cmd.wsel == drt_pkg::WR_COLLAPSE) begin
      held <= CW'(1);
    end else if (cmd.wsel == drt_pkg::WR_APPEND) begin
      held <= held + 1'b1;
    end else if (cmd.dec_held) begin
      held <= held_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      j <= '0;
    end else begin
      if (cmd.clr_i) begin
        i <= '0;
      end else if (cmd.inc_i) begin
        i <= i + 1'b1;
      end
      if (cmd.set_j) begin
        j <= i + 1'b1;
      end else if (cmd.inc_j) begin
        j <= j + 1'b1;
      end
    end
  end

  // status
  always_comb begin
    stat.is_mark    = (req_q == drt_pkg::REQ_MARK);
    stat.is_clear   = (req_q == drt_pkg::REQ_CLEAR);
    stat.is_read    = (req_q == drt_pkg::REQ_READ);
    stat.mark_ok    = tracking_enable && clip_ok;
    stat.full       = (held8 >= 8'(max_entries)) || (held8 >= 8'(TABLE_DEPTH));
    stat.ge4        = (held8 >= 8'(drt_pkg::MERGE_MIN));
    stat.i_lt       = (i8 < held8);
    stat.j_lt       = (j8 < held8);
    stat.j_not_last = ((j8 + 8'd1) < held8);
    stat.overlap    = overlap;
  end

  // result
  logic        hit;
  logic [15:0] ox, oy, ow, oh;

  assign hit = stat.is_read && (idx8 < held8) && (idx8 < 8'(TABLE_DEPTH));
  assign ox  = 16'(rd_l);
  assign oy  = 16'(rd_t);
  assign ow  = 16'(rd_w);
  assign oh  = 16'(rd_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      entry_count  <= held8[drt_pkg::COUNT_W-1:0];
      entry_valid  <= hit;
      entry_x      <= hit ? ox[12:0] : 13'd0;
      entry_y      <= hit ? oy[12:0] : 13'd0;
      entry_width  <= hit ? ow[12:0] : 13'd0;
      entry_height <= hit ? oh[12:0] : 13'd0;
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held8 <= 8'(TABLE_DEPTH))
    else $error("held count above table depth");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.wsel == drt_pkg::WR_APPEND) |-> (held8 < 8'(TABLE_DEPTH)))
    else $error("append into a full table");

  a_writeback_in_table: assert property (@(posedge clk) disable iff (rst)
    (cmd.wsel == drt_pkg::WR_A) |-> (i8 < held8))
    else $error("merge write-back outside held entries");

  a_merge_pair: assert property (@(posedge clk) disable iff (rst)
    cmd.dec_held |-> (held8 >= 8'd2) && (i8 < j8))
    else $error("merge without a valid pair");

endmodule

/* hw/rtl/dirty_rect_tracker.sv */
// Dirty rectangle tracker: clips marks, keeps a merged damage table, answers reads.
// From accept to done: clear, read, dropped or collapsing marks pass through decode and done;
// an append adds a check state; with four or more entries held it adds a merge pass over
// every entry i and every pair compare, paced by the single table read port.
// One item at a time; busy stays high until done. Receiver cannot stall.
// Reset clears the entry count and loads register defaults; table contents stay undefined.
module dirty_rect_tracker #(
  parameter int TABLE_DEPTH = drt_pkg::DEPTH_DEFAULT,
  parameter int COORD_BITS  = drt_pkg::COORD_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_addr,
  input  logic [12:0]                 cfg_data,
  input  logic [1:0]                  req_type,
  input  logic signed [15:0]          rect_x,
  input  logic signed [15:0]          rect_y,
  input  logic [15:0]                 rect_width,
  input  logic [15:0]                 rect_height,
  input  logic [3:0]                  read_index,
  output logic                        done,
  output logic [drt_pkg::COUNT_W-1:0] entry_count,
  output logic                        entry_valid,
  output logic [12:0]                 entry_x,
  output logic [12:0]                 entry_y,
  output logic [12:0]                 entry_width,
  output logic [12:0]                 entry_height
);

  drt_pkg::cmd_t  cmd;
  drt_pkg::stat_t stat;

  drt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  drt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .rect_x       (rect_x),
    .rect_y       (rect_y),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .read_index   (read_index),
    .cmd          (cmd),
    .stat         (stat),
    .done         (done),
    .entry_count  (entry_count),
    .entry_valid  (entry_valid),
    .entry_x      (entry_x),
    .entry_y      (entry_y),
    .entry_width  (entry_width),
    .entry_height (entry_height)
  );

endmodule

/* bench/drt_checker.sv */
`timescale 1ns / 100ps
// drt_checker: watches the request, config and result ports of dirty_rect_tracker,
// predicts each answer from its own copy of the damage table and compares. Uses drt_pkg.
module drt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_data,
  input  logic [1:0]  req_type,
  input  logic [15:0] rect_x,
  input  logic [15:0] rect_y,
  input  logic [15:0] rect_width,
  input  logic [15:0] rect_height,
  input  logic [3:0]  read_index,
  input  logic        done,
  input  logic [4:0]  entry_count,
  input  logic        entry_valid,
  input  logic [12:0] entry_x,
  input  logic [12:0] entry_y,
  input  logic [12:0] entry_width,
  input  logic [12:0] entry_height,
  output int          pending,
  output int          fail_count,
  output int          result_count
);

  localparam int DEPTH = 16;

  typedef struct packed {
    logic [4:0]  count;
    logic        valid;
    logic [12:0] x;
    logic [12:0] y;
    logic [12:0] w;
    logic [12:0] h;
  } answer_t;

  answer_t answer_q[$];

  logic        track_en;
  logic [12:0] scr_w;
  logic [12:0] scr_h;
  logic [4:0]  max_held;
  int          tbl_l[DEPTH];
  int          tbl_t[DEPTH];
  int          tbl_w[DEPTH];
  int          tbl_h[DEPTH];
  int          held;

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void store(int k, int l, int t, int w, int h);
    tbl_l[k] = l & 13'h1fff;
    tbl_t[k] = t & 13'h1fff;
    tbl_w[k] = w & 13'h1fff;
    tbl_h[k] = h & 13'h1fff;
  endfunction

  // one forward pass; a merged pair's hole is filled from the last entry
  function automatic void merge_overlaps();
    int i, j, ar, ab, br, bb, l, t, r, b;
    for (i = 0; i < held; i++) begin
      j = i + 1;
      while (j < held) begin
        ar = tbl_l[i] + tbl_w[i];
        ab = tbl_t[i] + tbl_h[i];
        br = tbl_l[j] + tbl_w[j];
        bb = tbl_t[j] + tbl_h[j];
        if (tbl_l[i] < br && ar > tbl_l[j] && tbl_t[i] < bb && ab > tbl_t[j]) begin
          l = tbl_l[i] < tbl_l[j] ? tbl_l[i] : tbl_l[j];
          t = tbl_t[i] < tbl_t[j] ? tbl_t[i] : tbl_t[j];
          r = ar > br ? ar : br;
          b = ab > bb ? ab : bb;
          store(i, l, t, r - l, b - t);
          if (j < held - 1) begin
            tbl_l[j] = tbl_l[held-1];
            tbl_t[j] = tbl_t[held-1];
            tbl_w[j] = tbl_w[held-1];
            tbl_h[j] = tbl_h[held-1];
          end
          held--;
        end else begin
          j++;
        end
      end
    end
  endfunction

  function automatic void mark_damage(logic signed [15:0] x, logic signed [15:0] y,
                                      int w, int h);
    int l, t, r, b, limit;
    if (!track_en || w == 0 || h == 0) return;
    l = x < 0 ? 0 : int'(x);
    t = y < 0 ? 0 : int'(y);
    r = int'(x) + w;
    b = int'(y) + h;
    if (r > int'(scr_w)) r = int'(scr_w);
    if (b > int'(scr_h)) b = int'(scr_h);
    if (r <= l || b <= t) return;
    limit = max_held > DEPTH ? DEPTH : int'(max_held);
    if (held >= limit) begin
      held = 1;
      store(0, 0, 0, int'(scr_w), int'(scr_h));
      return;
    end
    store(held, l, t, r - l, b - t);
    held++;
    if (held >= drt_pkg::MERGE_MIN) merge_overlaps();
  endfunction

  function automatic answer_t predict_answer();
    answer_t a;
    a = '0;
    case (req_type)
      drt_pkg::REQ_MARK:  mark_damage(rect_x, rect_y, int'(rect_width), int'(rect_height));
      drt_pkg::REQ_CLEAR: held = 0;
      drt_pkg::REQ_READ: begin
        if (int'(read_index) < held) begin
          a.valid = 1'b1;
          a.x = 13'(tbl_l[read_index]);
          a.y = 13'(tbl_t[read_index]);
          a.w = 13'(tbl_w[read_index]);
          a.h = 13'(tbl_h[read_index]);
        end
      end
      default: ;
    endcase
    a.count = 5'(held);
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      track_en <= 1'b1;
      scr_w    <= drt_pkg::WIDTH_RESET;
      scr_h    <= drt_pkg::HEIGHT_RESET;
      max_held <= drt_pkg::MAX_RESET;
      held     = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_addr)
          drt_pkg::CFG_ENABLE: track_en <= cfg_data[0];
          drt_pkg::CFG_WIDTH:  scr_w    <= cfg_data;
          drt_pkg::CFG_HEIGHT: scr_h    <= cfg_data;
          drt_pkg::CFG_MAX:    max_held <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (start && !busy) answer_q.push_back(predict_answer());
      if (done) begin
        result_count++;
        if (answer_q.size() == 0) begin
          report("unexpected result, count", int'(entry_count), -1);
        end else begin
          want = answer_q.pop_front();
          if (entry_count !== want.count)
            report("entry_count", int'(entry_count), int'(want.count));
          if (entry_valid !== want.valid)
            report("entry_valid", int'(entry_valid), int'(want.valid));
          if (entry_x !== want.x) report("entry_x", int'(entry_x), int'(want.x));
          if (entry_y !== want.y) report("entry_y", int'(entry_y), int'(want.y));
          if (entry_width !== want.w)
            report("entry_width", int'(entry_width), int'(want.w));
          if (entry_height !== want.h)
            report("entry_height", int'(entry_height), int'(want.h));
        end
      end
    end
    pending <= answer_q.size();
  end

  initial begin
    fail_count   = 0;
    result_count = 0;
    pending      = 0;
  end
endmodule

/* bench/tb_dirty_rect_tracker.sv */
`timescale 1ns / 100ps
// tb_dirty_rect_tracker: drives requests and register writes into dirty_rect_tracker
// and gives the verdict; prediction and comparison live in drt_checker. Uses drt_pkg.
module tb_dirty_rect_tracker;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        cfg_write;
  logic [1:0]  cfg_addr;
  logic [12:0] cfg_data;
  logic [1:0]  req_type;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic [15:0] rect_width;
  logic [15:0] rect_height;
  logic [3:0]  read_index;
  logic        done;
  logic [4:0]  entry_count;
  logic        entry_valid;
  logic [12:0] entry_x;
  logic [12:0] entry_y;
  logic [12:0] entry_width;
  logic [12:0] entry_height;
  int          pending;
  int          fail_count;
  int          result_count;
  logic        steady;
  int          cur_w;
  int          cur_h;

  dirty_rect_tracker u_dut (.*);

  drt_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Timeout waiting for the block");
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(input logic [1:0] req, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] w, input logic [15:0] h,
                           input logic [3:0] idx);
    if (!steady && $urandom_range(99) < 19) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    start       <= 1'b1;
    req_type    <= req;
    rect_x      <= x;
    rect_y      <= y;
    rect_width  <= w;
    rect_height <= h;
    read_index  <= idx;
    // hold until accepted
    do @(posedge clk); while (busy);
  endtask

  // wait until the last accepted item has produced its result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [12:0] data);
    drain();
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (addr == drt_pkg::CFG_WIDTH) cur_w = int'(data);
    if (addr == drt_pkg::CFG_HEIGHT) cur_h = int'(data);
  endtask

  // mostly small on-screen marks so the table fills and merges; some wild ones
  task automatic random_item();
    int pick;
    logic [15:0] x, y, w, h;
    pick = $urandom_range(99);
    x = 16'($urandom_range(cur_w - 1));
    y = 16'($urandom_range(cur_h - 1));
    w = 16'($urandom_range(1, (cur_w / 6) + 2));
    h = 16'($urandom_range(1, (cur_h / 6) + 2));
    if (pick < 60) begin
      send_item(drt_pkg::REQ_MARK, x, y, w, h, 4'($urandom));
    end else if (pick < 70) begin
      send_item(drt_pkg::REQ_MARK, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 4'($urandom));
    end else if (pick < 75) begin
      send_item(drt_pkg::REQ_MARK, x - 16'($urandom_range(40)), y - 16'($urandom_range(40)),
                w + 16'($urandom_range(60)), h, 4'($urandom));
    end else if (pick < 78) begin
      send_item(drt_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 4'($urandom));
    end else if (pick < 80) begin
      send_item(2'd3, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                4'($urandom));
    end else begin
      send_item(drt_pkg::REQ_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 4'($urandom));
    end
  endtask

  task automatic read_all();
    for (int i = 0; i < 16; i++) send_item(drt_pkg::REQ_READ, 0, 0, 0, 0, 4'(i));
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cfg_write = 1'b0;
    cfg_addr = drt_pkg::CFG_ENABLE;
    cfg_data = '0;
    req_type = drt_pkg::REQ_MARK;
    rect_x = '0;
    rect_y = '0;
    rect_width = '0;
    rect_height = '0;
    read_index = '0;
    steady = 1'b0;
    cur_w = int'(drt_pkg::WIDTH_RESET);
    cur_h = int'(drt_pkg::HEIGHT_RESET);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, every request code and the corner cases
    send_item(drt_pkg::REQ_READ, 0, 0, 0, 0, 4'd15);
    send_item(drt_pkg::REQ_MARK, 16'h8000, 16'h8000, 16'hffff, 16'hffff, 0);
    send_item(drt_pkg::REQ_MARK, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 0);
    send_item(drt_pkg::REQ_MARK, 10, 10, 0, 5, 0);
    send_item(drt_pkg::REQ_MARK, 10, 10, 5, 0, 0);
    send_item(drt_pkg::REQ_MARK, -16'sd20, -16'sd20, 10, 10, 0);
    send_item(drt_pkg::REQ_MARK, 100, 100, 50, 50, 0);
    send_item(drt_pkg::REQ_MARK, 120, 120, 50, 50, 0);
    send_item(drt_pkg::REQ_MARK, 1900, 1070, 100, 100, 0);
    send_item(drt_pkg::REQ_MARK, 400, 400, 10, 10, 0);
    read_all();
    send_item(2'd3, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 4'hf);
    send_item(drt_pkg::REQ_CLEAR, 0, 0, 0, 0, 0);
    send_item(drt_pkg::REQ_READ, 0, 0, 0, 0, 0);

    write_reg(drt_pkg::CFG_ENABLE, 13'd0);
    send_item(drt_pkg::REQ_MARK, 5, 5, 5, 5, 0);
    send_item(drt_pkg::REQ_READ, 0, 0, 0, 0, 0);
    write_reg(drt_pkg::CFG_ENABLE, 13'd1);
    write_reg(drt_pkg::CFG_MAX, 13'd0);
    send_item(drt_pkg::REQ_MARK, 5, 5, 5, 5, 0);
    send_item(drt_pkg::REQ_READ, 0, 0, 0, 0, 0);
    write_reg(drt_pkg::CFG_MAX, 13'd20);
    for (int k = 0; k < 20; k++)
      send_item(drt_pkg::REQ_MARK, 16'(k * 90), 16'(k * 50), 20, 20, 0);
    read_all();

    // random phases over several screen and limit settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(drt_pkg::CFG_WIDTH, 13'd64); write_reg(drt_pkg::CFG_HEIGHT, 13'd48);
          write_reg(drt_pkg::CFG_MAX, 13'd8);
        end
        1: begin
          write_reg(drt_pkg::CFG_WIDTH, 13'd4096); write_reg(drt_pkg::CFG_HEIGHT, 13'd4096);
          write_reg(drt_pkg::CFG_MAX, 13'd16);
        end
        2: begin
          write_reg(drt_pkg::CFG_WIDTH, 13'd1); write_reg(drt_pkg::CFG_HEIGHT, 13'd1);
          write_reg(drt_pkg::CFG_MAX, 13'd1);
        end
        3: begin
          write_reg(drt_pkg::CFG_WIDTH, 13'd320); write_reg(drt_pkg::CFG_HEIGHT, 13'd200);
          write_reg(drt_pkg::CFG_MAX, 13'd12);
        end
        4: begin
          write_reg(drt_pkg::CFG_ENABLE, 13'd0);
        end
        default: begin
          write_reg(drt_pkg::CFG_ENABLE, 13'd1); write_reg(drt_pkg::CFG_WIDTH, 13'd1920);
          write_reg(drt_pkg::CFG_HEIGHT, 13'd1080); write_reg(drt_pkg::CFG_MAX, 13'd16);
        end
      endcase
      steady = (phase == 3);
      for (int n = 0; n < (phase == 4 ? 40 : 130); n++) random_item();
      steady = 1'b0;
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d results over marks, clears, reads and unused codes,", result_count);
    $display("with screens from 1x1 to 4096x4096 and occupancy limits from 0 to 20.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
